@@ hw/rtl/svma_pkg.sv @@
// shared types and constants for the supply voltage moving average
`default_nettype none

package svma_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DVS_W    = 16;
    localparam int RES_W    = 16;

    // items that refill the whole ring after reset
    localparam logic [3:0] PREFILL_START = 4'd10;
    // times four is a shift by two
    localparam int SCALE_SHIFT = 2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

@@ hw/rtl/svma_ring.sv @@
// sample ring storage, one write and one registered read port
`default_nettype none

module svma_ring #(
    parameter int DEPTH = 8,
    parameter int IW    = 3
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [IW-1:0]                 i_wr_addr,
    input  wire logic [svma_pkg::SAMPLE_W-1:0] i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [IW-1:0]                 i_rd_addr,
    output logic      [svma_pkg::SAMPLE_W-1:0] o_rd_data
);

    logic [svma_pkg::SAMPLE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/svma_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none

module svma_div #(
    parameter int DW = 19
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [DW-1:0]              i_dividend,
    input  wire logic [svma_pkg::DVS_W-1:0] i_divisor,
    output logic      [DW-1:0]              o_quotient,
    output svma_pkg::t_div_stat             o_stat
);

    localparam int VW = svma_pkg::DVS_W;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW-1:0] r_dvs, n_dvs;

    logic [VW:0]   shifted;
    logic [VW+1:0] diff;
    logic          ge;

    assign shifted = {r_rem, r_quo[DW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dvs};
    assign ge      = ~diff[VW+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[DW-2:0], ge};
            n_rem = ge ? diff[VW-1:0] : shifted[VW-1:0];
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

@@ hw/rtl/supply_voltage_moving_average.sv @@
// top level: supply voltage moving average with prefill and scaling
// Input stream: s_axis_tdata carries the 16-bit converter sample, s_axis_tuser[0]
// the store flag. Output stream: m_axis_tdata carries voltage_x10 (16 bits).
// The config port writes scale_divisor whenever i_cfg_wr_en is high; zero acts as one.
// One transaction is worked on at a time. The ring sits in a one-port-read,
// one-port-write memory; a store does a read-modify-write, the first ten
// items after reset instead sweep the whole ring. The mean comes from a
// reciprocal multiply of the running sum, registered in the mean state; the
// scaling by the divisor runs through a serial divider, one bit per cycle over
// DW = 18 bits. A store passes the read, read-modify-write, mean, scale,
// divider wait and output states in order; an item without store skips the
// first two, and a prefill item takes the fill state in their place. Input is
// ready again in the same cycle as the result lands in the output register,
// and the next transaction is taken while a result waits. If the receiver
// stalls with a result still held, the next result waits in the final state
// and input stays not ready.
// Synchronous reset clears the index, sum, prefill countdown (to ten), divisor
// (to one) and output valid; the ring contents are left as they are.
`default_nettype none

module supply_voltage_moving_average #(
    parameter int RING_DEPTH = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] adc_sample
    input  wire logic [15:0]                   s_axis_tdata,
    // [0] store_sample
    input  wire logic [0:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [15:0] voltage_x10
    output logic      [15:0]                   m_axis_tdata,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [svma_pkg::DVS_W-1:0]    i_cfg_wr_data
);

    localparam int SW = svma_pkg::SAMPLE_W + $clog2(RING_DEPTH);
    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RW = svma_pkg::RES_W;
    localparam int DW = RW + svma_pkg::SCALE_SHIFT;

    // sum / RING_DEPTH as a multiply by a rounded-up reciprocal, exact for any SW-bit sum
    localparam int          MEAN_SH  = SW + $clog2(RING_DEPTH);
    localparam int          MW       = MEAN_SH + 1;
    localparam int          PW       = SW + MW;
    localparam logic [63:0] MEAN_MUL = ((64'd1 << MEAN_SH) + 64'(RING_DEPTH) - 64'd1)
                                       / 64'(RING_DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FILL  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_RMW   = 4'd3;
    localparam logic [3:0] S_MEAN  = 4'd4;
    localparam logic [3:0] S_SCALE = 4'd6;
    localparam logic [3:0] S_SWAIT = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]                    r_state, n_state;
    logic [svma_pkg::SAMPLE_W-1:0] r_sample, n_sample;
    logic                          r_store, n_store;
    logic [3:0]                    r_prefill, n_prefill;
    logic [IW-1:0]                 r_widx, n_widx;
    logic [IW-1:0]                 r_fill_idx, n_fill_idx;
    logic [SW-1:0]                 r_sum, n_sum;
    logic [RW-1:0]                 r_mean, n_mean;
    logic                          r_out_valid, n_out_valid;
    logic [RW-1:0]                 r_out_data, n_out_data;
    logic [svma_pkg::DVS_W-1:0]    r_divisor;

    logic                          accept;
    logic                          out_free;
    logic [IW-1:0]                 widx_next;
    logic [IW-1:0]                 wr_addr;
    logic                          wr_en;
    logic                          rd_en;
    logic [svma_pkg::SAMPLE_W-1:0] rd_data;
    logic [PW-1:0]                 mean_prod;
    logic                          div_start;
    logic [DW-1:0]                 div_dividend;
    logic [svma_pkg::DVS_W-1:0]    div_divisor;
    logic [DW-1:0]                 div_quotient;
    svma_pkg::t_div_stat           div_stat;
    logic [RW-1:0]                 result_sat;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign widx_next     = (r_widx == IW'(RING_DEPTH - 1)) ? '0 : r_widx + IW'(1);

    assign wr_en   = (r_state == S_FILL) || (r_state == S_RMW);
    assign wr_addr = (r_state == S_FILL) ? r_fill_idx : r_widx;
    assign rd_en   = (r_state == S_READ);

    assign mean_prod = PW'(r_sum) * PW'(MEAN_MUL);

    assign div_start    = (r_state == S_SCALE);
    assign div_dividend = DW'({r_mean, 2'b00});
    assign div_divisor  = (r_divisor == '0) ? svma_pkg::DVS_W'(1) : r_divisor;

    assign result_sat = (div_quotient[DW-1:RW] != '0) ? {RW{1'b1}} : div_quotient[RW-1:0];

    svma_ring #(
        .DEPTH (RING_DEPTH),
        .IW    (IW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_widx),
        .o_rd_data (rd_data)
    );

    svma_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quotient),
        .o_stat     (div_stat)
    );

    always_comb begin
        n_state     = r_state;
        n_sample    = r_sample;
        n_store     = r_store;
        n_prefill   = r_prefill;
        n_widx      = r_widx;
        n_fill_idx  = r_fill_idx;
        n_sum       = r_sum;
        n_mean      = r_mean;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_sample = s_axis_tdata;
                    n_store  = s_axis_tuser[0];
                    if (r_prefill != 4'd0) begin
                        // every entry becomes the sample, so a store in the same
                        // transaction leaves the sum as it is
                        n_sum      = SW'(s_axis_tdata) * SW'(RING_DEPTH);
                        n_prefill  = r_prefill - 4'd1;
                        n_fill_idx = '0;
                        n_state    = S_FILL;
                    end else if (s_axis_tuser[0]) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_MEAN;
                    end
                end
            end
            S_FILL: begin
                if (r_fill_idx == IW'(RING_DEPTH - 1)) begin
                    if (r_store) begin
                        n_widx = widx_next;
                    end
                    n_state = S_MEAN;
                end else begin
                    n_fill_idx = r_fill_idx + IW'(1);
                end
            end
            S_READ: begin
                n_state = S_RMW;
            end
            S_RMW: begin
                n_sum   = r_sum - SW'(rd_data) + SW'(r_sample);
                n_widx  = widx_next;
                n_state = S_MEAN;
            end
            S_MEAN: begin
                n_mean  = mean_prod[MEAN_SH +: RW];
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                if (div_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = result_sat;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prefill   <= svma_pkg::PREFILL_START;
            r_widx      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_divisor   <= svma_pkg::DVS_W'(1);
        end else begin
            r_state     <= n_state;
            r_prefill   <= n_prefill;
            r_widx      <= n_widx;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_divisor <= i_cfg_wr_data;
            end
        end
        r_sample   <= n_sample;
        r_store    <= n_store;
        r_fill_idx <= n_fill_idx;
        r_mean     <= n_mean;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_prefill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_prefill != $past(r_prefill)))
            |-> (r_prefill == $past(r_prefill) - 4'd1))
        else $error("prefill countdown moved by other than one");

    a_widx_on_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_widx != $past(r_widx))) |-> $past(r_store))
        else $error("write index moved without a store");

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_accept_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (!div_stat.busy && !wr_en))
        else $error("transaction accepted while previous work in flight");

endmodule

`default_nettype wire
